// File: rtl/spmv_pkg.sv
// ----------------------------------------------------------------------------
// spmv_pkg: shared types and constants for the CSR matrix-vector multiplier
// Command codes, field widths and the control word that travels with each
// item down the multiply and accumulate stages.
// ----------------------------------------------------------------------------
`default_nettype none

package spmv_pkg;

    // Field widths fixed by the item format
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned COL_W  = 12;
    localparam int unsigned ROW_W  = 12;
    localparam int unsigned IN_W   = 32;
    localparam int unsigned ACC_W  = 64;
    localparam int unsigned FLAG_W = 2;
    localparam int unsigned CC_W   = 13;
    // Wide enough to hold the largest supported column limit
    localparam int unsigned CMP_W  = 17;

    localparam logic [CC_W-1:0] CC_RESET = 13'd4096;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NONZERO = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd2;

    // Flag bit positions
    localparam int unsigned FLAG_BAD_COL = 0;
    localparam int unsigned FLAG_SAT     = 1;

    // Control word carried with a nonzero or close item
    typedef struct packed {
        logic nonzero;
        logic col_ok;
        logic close;
    } spmv_ctl_t;

endpackage

`default_nettype wire

// File: rtl/csr_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// csr_matrix_vector_multiply: streaming CSR sparse matrix times vector
// Input items on the s_ channel either load one vector element, carry one
// matrix nonzero, or close an empty row. Each closed row leaves as one item
// on the m_ channel: row index, saturated Q32.32 sum and two flags.
// Usage: load the vector first, then stream the nonzeros row by row; set
// column_count through cfg_wr_en / cfg_wr_data while the block is idle.
// Throughput: one item per cycle while s_ready is high; a nonzero or close
// item passes an input register with the vector memory read, a product
// register fed by one VALUE_BITS x VALUE_BITS multiplier, and the
// accumulator with the result register, in that order.
// Loads finish in the cycle they are taken and emit nothing.
// Stall: when m_ready is low the result register holds; items that close
// no row keep flowing, and the stages fill before s_ready drops.
// Reset: column_count returns to 4096, the accumulator, flags and row
// counter clear and all stages empty. Vector memory contents are not
// cleared; every element must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_matrix_vector_multiply #(
    parameter int unsigned MAX_COLUMNS = 4096,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Configuration
    input  wire logic                                 cfg_wr_en,
    input  wire logic [spmv_pkg::CC_W-1:0]            cfg_wr_data,
    // Input items
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [spmv_pkg::CMD_W-1:0]           s_command,
    input  wire logic [spmv_pkg::COL_W-1:0]           s_column,
    input  wire logic signed [spmv_pkg::IN_W-1:0]     s_entry_value,
    input  wire logic                                 s_row_end,
    // Result items
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [spmv_pkg::ROW_W-1:0]                m_row_index,
    output logic signed [spmv_pkg::ACC_W-1:0]         m_row_sum,
    output logic [spmv_pkg::FLAG_W-1:0]               m_row_flags
);

    import spmv_pkg::*;

    localparam int unsigned ADDR_W = $clog2(MAX_COLUMNS);

    logic [CC_W-1:0]                col_count_reg;
    logic [CMP_W-1:0]               width_lim;
    logic                           col_ok;
    logic                           accept;
    logic                           is_load;
    logic                           is_pipe;
    spmv_ctl_t                      ctl_in;
    logic [ADDR_W-1:0]              addr;
    logic signed [VALUE_BITS-1:0]   value_in;

    logic                           s1_valid_reg;
    spmv_ctl_t                      s1_ctl_reg;
    logic signed [VALUE_BITS-1:0]   s1_value_reg;
    logic signed [VALUE_BITS-1:0]   x_data;

    logic                           mul_in_ready;
    logic                           mul_valid;
    spmv_ctl_t                      mul_ctl;
    logic signed [2*VALUE_BITS-1:0] mul_product;
    logic                           acc_in_ready;

    // Column limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= CC_RESET;
        end else if (cfg_wr_en) begin
            col_count_reg <= cfg_wr_data;
        end
    end

    // Clamp the limit to the memory depth and check the column
    assign width_lim = (CMP_W'(col_count_reg) > CMP_W'(MAX_COLUMNS))
                     ? CMP_W'(MAX_COLUMNS) : CMP_W'(col_count_reg);
    assign col_ok    = CMP_W'(s_column) < width_lim;
    assign addr      = ADDR_W'(s_column);
    assign value_in  = s_entry_value[VALUE_BITS-1:0];

    // Decode the command
    always_comb begin
        is_load = 1'b0;
        is_pipe = 1'b0;
        ctl_in  = '0;
        unique case (s_command)
            CMD_LOAD: begin
                is_load = 1'b1;
            end
            CMD_NONZERO: begin
                is_pipe        = 1'b1;
                ctl_in.nonzero = 1'b1;
                ctl_in.col_ok  = col_ok;
                ctl_in.close   = s_row_end;
            end
            CMD_CLOSE: begin
                is_pipe      = 1'b1;
                ctl_in.close = 1'b1;
            end
            default: begin
                is_load = 1'b0;
            end
        endcase
    end

    assign s_ready = !s1_valid_reg || mul_in_ready;
    assign accept  = s_valid && s_ready;

    // Vector memory: write loads, read for nonzero and close items
    spmv_vector_store #(
        .DEPTH  (MAX_COLUMNS),
        .DATA_W (VALUE_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept && is_load && col_ok),
        .wr_addr (addr),
        .wr_data (value_in),
        .rd_en   (accept && is_pipe),
        .rd_addr (addr),
        .rd_data (x_data)
    );

    // Input stage occupancy; loads and unused codes do not enter it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= is_pipe;
        end else if (mul_in_ready) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Input stage payload
    always_ff @(posedge aclk) begin
        if (accept && is_pipe) begin
            s1_ctl_reg   <= ctl_in;
            s1_value_reg <= value_in;
        end
    end

    spmv_multiply #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mul (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s1_valid_reg),
        .in_ready    (mul_in_ready),
        .in_ctl      (s1_ctl_reg),
        .in_value    (s1_value_reg),
        .in_x        (x_data),
        .out_valid   (mul_valid),
        .out_ready   (acc_in_ready),
        .out_ctl     (mul_ctl),
        .out_product (mul_product)
    );

    spmv_accumulate #(
        .VALUE_BITS (VALUE_BITS)
    ) u_acc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (mul_valid),
        .in_ready    (acc_in_ready),
        .in_ctl      (mul_ctl),
        .in_product  (mul_product),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_index (m_row_index),
        .m_row_sum   (m_row_sum),
        .m_row_flags (m_row_flags)
    );

endmodule

`default_nettype wire

// File: rtl/spmv_vector_store.sv
// ----------------------------------------------------------------------------
// spmv_vector_store: vector element memory
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_vector_store #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned DATA_W = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [DATA_W-1:0]          wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write a loaded element
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read an element, hold it while the item waits
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/spmv_multiply.sv
// ----------------------------------------------------------------------------
// spmv_multiply: product stage
// Multiplies the nonzero value by the stored vector element and registers
// the exact product together with the item's control word.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_multiply #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire spmv_pkg::spmv_ctl_t               in_ctl,
    input  wire logic signed [VALUE_BITS-1:0]      in_value,
    input  wire logic signed [VALUE_BITS-1:0]      in_x,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output spmv_pkg::spmv_ctl_t                    out_ctl,
    output logic signed [2*VALUE_BITS-1:0]         out_product
);

    import spmv_pkg::*;

    logic                           valid_reg;
    spmv_ctl_t                      ctl_reg;
    logic signed [2*VALUE_BITS-1:0] product_reg;
    logic signed [2*VALUE_BITS-1:0] product_next;
    logic                           take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Form the exact product
    assign product_next = in_value * in_x;

    // Track stage occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the product and control word
    always_ff @(posedge aclk) begin
        if (take) begin
            ctl_reg     <= in_ctl;
            product_reg <= product_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_ctl     = ctl_reg;
    assign out_product = product_reg;

endmodule

`default_nettype wire

// File: rtl/spmv_accumulate.sv
// ----------------------------------------------------------------------------
// spmv_accumulate: row accumulator and result register
// Adds each product into a saturating Q32.32 accumulator, collects the row
// flags, and on a row close loads the result register and starts a new row.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_accumulate #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire spmv_pkg::spmv_ctl_t                  in_ctl,
    input  wire logic signed [2*VALUE_BITS-1:0]       in_product,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [spmv_pkg::ROW_W-1:0]                m_row_index,
    output logic signed [spmv_pkg::ACC_W-1:0]         m_row_sum,
    output logic [spmv_pkg::FLAG_W-1:0]               m_row_flags
);

    import spmv_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [FLAG_W-1:0]       err_reg;
    logic [FLAG_W-1:0]       err_next;
    logic [ROW_W-1:0]        row_cnt_reg;
    logic                    out_valid_reg;
    logic [ROW_W-1:0]        out_row_reg;
    logic signed [ACC_W-1:0] out_sum_reg;
    logic [FLAG_W-1:0]       out_flags_reg;

    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] sat_val;
    logic                    ovf;
    logic                    take;

    // A closing item needs a free result register; others pass freely
    assign in_ready = !in_ctl.close || !out_valid_reg || m_ready;
    assign take     = in_valid && in_ready;

    // Saturating add of the sign-extended product
    assign prod_ext = ACC_W'(in_product);
    assign sum      = acc_reg + prod_ext;
    assign ovf      = (acc_reg[ACC_W-1] == prod_ext[ACC_W-1]) &&
                      (sum[ACC_W-1] != acc_reg[ACC_W-1]);
    assign sat_val  = acc_reg[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                       : {1'b0, {(ACC_W-1){1'b1}}};

    // Update the running sum and the flags for this item
    always_comb begin
        acc_next = acc_reg;
        err_next = err_reg;
        if (in_ctl.nonzero) begin
            if (in_ctl.col_ok) begin
                acc_next = ovf ? sat_val : sum;
                if (ovf) begin
                    err_next[FLAG_SAT] = 1'b1;
                end
            end else begin
                err_next[FLAG_BAD_COL] = 1'b1;
            end
        end
    end

    // Row state: accumulate, or emit and clear on close
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            err_reg     <= '0;
            row_cnt_reg <= '0;
        end else if (take) begin
            if (in_ctl.close) begin
                acc_reg     <= '0;
                err_reg     <= '0;
                row_cnt_reg <= row_cnt_reg + ROW_W'(1);
            end else begin
                acc_reg <= acc_next;
                err_reg <= err_next;
            end
        end
    end

    // Result register occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && in_ctl.close) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (take && in_ctl.close) begin
            out_row_reg   <= row_cnt_reg;
            out_sum_reg   <= acc_next;
            out_flags_reg <= err_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_row_index = out_row_reg;
    assign m_row_sum   = out_sum_reg;
    assign m_row_flags = out_flags_reg;

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for csr_matrix_vector_multiply
// Drives load, nonzero and close items into the s_ channel and compares each
// row item on the m_ channel against a local fixed-point model of the
// multiply and saturating accumulate. Covers value extremes, saturation both
// ways, bad columns and bad loads, loads inside rows and a series of
// column_count settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import spmv_pkg::*;

    localparam int unsigned MAX_COLS       = 4096;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // Close item to result item, plus margin for items still in flight
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned QUIET_LIMIT    = 4000;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic signed [ACC_W-1:0]  sum;
        logic [FLAG_W-1:0]        flags;
    } row_result_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CC_W-1:0]            cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_command;
    logic [COL_W-1:0]           s_column;
    logic signed [IN_W-1:0]     s_entry_value;
    logic                       s_row_end;
    logic                       m_valid;
    logic                       m_ready;
    logic [ROW_W-1:0]           m_row_index;
    logic signed [ACC_W-1:0]    m_row_sum;
    logic [FLAG_W-1:0]          m_row_flags;

    // Local copy of the block state
    logic signed [IN_W-1:0]     x_mirror [MAX_COLS];
    bit                         x_loaded [MAX_COLS];
    logic signed [ACC_W-1:0]    acc_mirror;
    logic [ROW_W-1:0]           row_mirror;
    logic [FLAG_W-1:0]          flag_mirror;
    logic [CC_W-1:0]            width_mirror;

    row_result_t                pending_rows [$];
    int unsigned                live_cols [$];

    int unsigned                mismatches;
    int unsigned                rows_checked;
    int unsigned                sat_rows;
    int unsigned                bad_col_rows;
    int unsigned                items_sent;
    int unsigned                widths_tried;
    int unsigned                quiet_cycles;
    int unsigned                stall_left;
    bit                         idle_on;
    bit                         stall_on;

    csr_matrix_vector_multiply u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_column      (s_column),
        .s_entry_value (s_entry_value),
        .s_row_end     (s_row_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_index   (m_row_index),
        .m_row_sum     (m_row_sum),
        .m_row_flags   (m_row_flags)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Gap length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mix of extremes, zero, small Q16.16 values and raw random words
    function automatic logic signed [IN_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned usable_cols();
        return (width_mirror > MAX_COLS) ? MAX_COLS : width_mirror;
    endfunction

    // Apply one accepted item to the local state; queue the row it closes
    task automatic advance_row_sum(input logic [CMD_W-1:0] cmd, input logic [COL_W-1:0] col,
                                   input logic signed [IN_W-1:0] val, input logic last);
        logic                    col_ok;
        logic                    closes;
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W-1:0] s;
        col_ok = (int'(col) < usable_cols());
        closes = 1'b0;
        case (cmd)
            CMD_LOAD: begin
                if (col_ok) begin
                    x_mirror[col] = val;
                    x_loaded[col] = 1'b1;
                end
            end
            CMD_NONZERO: begin
                if (col_ok) begin
                    a = val;
                    b = x_mirror[col];
                    prod = a * b;
                    s = acc_mirror + prod;
                    // Clamp on signed overflow and keep the flag for the row
                    if (acc_mirror[ACC_W-1] == prod[ACC_W-1] &&
                        s[ACC_W-1] != acc_mirror[ACC_W-1]) begin
                        s = acc_mirror[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                : {1'b0, {(ACC_W-1){1'b1}}};
                        flag_mirror[FLAG_SAT] = 1'b1;
                    end
                    acc_mirror = s;
                end else begin
                    flag_mirror[FLAG_BAD_COL] = 1'b1;
                end
                closes = last;
            end
            CMD_CLOSE: closes = 1'b1;
            default: ;
        endcase
        if (closes) begin
            pending_rows.push_back('{row_mirror, acc_mirror, flag_mirror});
            acc_mirror  = '0;
            flag_mirror = '0;
            row_mirror  = row_mirror + ROW_W'(1);
        end
    endtask

    // Present one item, hold it until taken, then update the model
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [COL_W-1:0] col,
                             input logic signed [IN_W-1:0] val, input logic last);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_column      <= col;
        s_entry_value <= val;
        s_row_end     <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        advance_row_sum(cmd, col, val, last);
    endtask

    // Drop valid and hold off until every row item has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_column_count(input int unsigned w);
        int unsigned k;
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w[CC_W-1:0];
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        width_mirror = w[CC_W-1:0];
        widths_tried++;
        // Rebuild the list of loaded columns that are in range
        live_cols.delete();
        for (k = 0; k < usable_cols(); k++) begin
            if (x_loaded[k]) live_cols.push_back(k);
        end
    endtask

    // Load a random in-range column and track it as usable
    task automatic load_random_col();
        int unsigned c;
        c = $urandom_range(0, usable_cols() - 1);
        if (!x_loaded[c]) live_cols.push_back(c);
        send_item(CMD_LOAD, c[COL_W-1:0], rand_value(), 1'($urandom_range(0, 1)));
    endtask

    // Reset width, value extremes, saturation, empty and early close
    task automatic test_directed_extremes();
        send_item(CMD_LOAD, 12'd0, 32'h7FFF_FFFF, 1'b0);
        send_item(CMD_LOAD, 12'd4095, 32'h8000_0000, 1'b1);
        send_item(CMD_LOAD, 12'd1, 32'h0001_0000, 1'b0);
        send_item(CMD_LOAD, 12'd2, 32'hFFFF_0000, 1'b0);
        // Plain two-term row
        send_item(CMD_NONZERO, 12'd1, 32'h0001_8000, 1'b0);
        send_item(CMD_NONZERO, 12'd2, 32'h0002_0000, 1'b1);
        // Empty row
        send_item(CMD_CLOSE, 12'd0, 32'h0, 1'b0);
        // Saturate high, then keep accumulating from the bound
        send_item(CMD_NONZERO, 12'd4095, 32'h8000_0000, 1'b0);
        send_item(CMD_NONZERO, 12'd4095, 32'h8000_0000, 1'b0);
        send_item(CMD_NONZERO, 12'd2, 32'h0000_0001, 1'b1);
        // Saturate low, skip an unused command, close the open row
        send_item(CMD_NONZERO, 12'd0, 32'h8000_0000, 1'b0);
        send_item(CMD_NONZERO, 12'd0, 32'h8000_0000, 1'b0);
        send_item(CMD_NONZERO, 12'd0, 32'h8000_0000, 1'b0);
        send_item(CMD_UNUSED, 12'd4095, 32'hFFFF_FFFF, 1'b1);
        send_item(CMD_CLOSE, 12'd4095, 32'hFFFF_FFFF, 1'b1);
        // Reload an element in the middle of a row
        send_item(CMD_NONZERO, 12'd1, 32'h7FFF_FFFF, 1'b0);
        send_item(CMD_LOAD, 12'd1, 32'hFFFF_0000, 1'b1);
        send_item(CMD_NONZERO, 12'd1, 32'h0001_0000, 1'b1);
        send_item(CMD_NONZERO, 12'd4095, 32'h0, 1'b1);
    endtask

    // Narrowest width: out-of-range loads and nonzeros
    task automatic test_bad_columns();
        set_column_count(1);
        send_item(CMD_LOAD, 12'd4095, 32'h1234_5678, 1'b0);
        send_item(CMD_LOAD, 12'd1, 32'h0003_0000, 1'b0);
        send_item(CMD_NONZERO, 12'd0, 32'h0001_0000, 1'b0);
        send_item(CMD_NONZERO, 12'd1, 32'h0000_0005, 1'b0);
        send_item(CMD_NONZERO, 12'd4095, 32'h0001_0000, 1'b1);
        send_item(CMD_NONZERO, 12'd2048, 32'h7FFF_FFFF, 1'b1);
        send_item(CMD_LOAD, 12'd0, 32'hFFFE_8000, 1'b0);
        send_item(CMD_NONZERO, 12'd0, 32'h0002_0000, 1'b1);
        // Full width again: the ignored loads must not have landed
        set_column_count(MAX_COLS);
        send_item(CMD_NONZERO, 12'd4095, 32'h0001_0000, 1'b0);
        send_item(CMD_NONZERO, 12'd1, 32'h0001_0000, 1'b1);
    endtask

    // One width setting with mostly well-formed rows and some noise
    task automatic random_rows_at(input int unsigned w, input int unsigned n_items);
        int unsigned sent;
        int unsigned next_toggle;
        int unsigned usable;
        int unsigned r;
        int unsigned len;
        int unsigned k;
        int unsigned c;
        bit          row_open;
        set_column_count(w);
        usable = usable_cols();
        sent = 0;
        next_toggle = 0;
        // Fill the vector: all of it when narrow, a spread when wide
        if (usable <= 64) begin
            for (k = 0; k < usable; k++) begin
                if (!x_loaded[k]) live_cols.push_back(k);
                send_item(CMD_LOAD, k[COL_W-1:0], rand_value(), 1'($urandom_range(0, 1)));
                sent++;
            end
        end else begin
            c = usable - 1;
            if (!x_loaded[c]) live_cols.push_back(c);
            send_item(CMD_LOAD, c[COL_W-1:0], rand_value(), 1'b0);
            repeat (24) load_random_col();
            sent += 25;
        end
        while (sent < n_items) begin
            // Switch input idling and result stalls on and off in stretches
            if (sent >= next_toggle) begin
                idle_on = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
                next_toggle = sent + $urandom_range(60, 140);
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                load_random_col();
                sent++;
            end else if (r < 80) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(1, 6);
                row_open = 1'b1;
                for (k = 0; k < len && row_open; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        load_random_col();
                        sent++;
                    end
                    if (k > 0 && $urandom_range(0, 29) == 0) begin
                        send_item(CMD_CLOSE, COL_W'($urandom), $urandom,
                                  1'($urandom_range(0, 1)));
                        sent++;
                        row_open = 1'b0;
                    end else begin
                        if (usable < MAX_COLS && $urandom_range(0, 9) == 0)
                            c = $urandom_range(usable, MAX_COLS - 1);
                        else
                            c = live_cols[$urandom_range(0, live_cols.size() - 1)];
                        send_item(CMD_NONZERO, c[COL_W-1:0], rand_value(), k == len - 1);
                        sent++;
                    end
                end
            end else if (r < 88) begin
                send_item(CMD_CLOSE, COL_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end else if (r < 93) begin
                send_item(CMD_UNUSED, COL_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end else if (r < 97) begin
                if (usable < MAX_COLS) begin
                    c = $urandom_range(usable, MAX_COLS - 1);
                    send_item(CMD_LOAD, c[COL_W-1:0], $urandom, 1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    load_random_col();
                    sent++;
                end
            end else begin
                wait_drained();
            end
        end
    endtask

    task automatic test_random_widths();
        random_rows_at(MAX_COLS, 300);
        random_rows_at(1, 80);
        random_rows_at(MAX_COLS - 1, 200);
        random_rows_at($urandom_range(2, 64), 250);
        random_rows_at($urandom_range(65, MAX_COLS - 2), 300);
        random_rows_at(MAX_COLS, 120);
    endtask

    // Result side: random stalls on m_ready
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each row item with the oldest expected row
    always @(posedge aclk) begin
        row_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected row item: row %0d sum %h flags %b",
                             m_row_index, m_row_sum, m_row_flags);
            end else begin
                want = pending_rows.pop_front();
                rows_checked++;
                if (want.flags[FLAG_SAT]) sat_rows++;
                if (want.flags[FLAG_BAD_COL]) bad_col_rows++;
                if (m_row_index !== want.row || m_row_sum !== want.sum ||
                    m_row_flags !== want.flags) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"row mismatch: expected row %0d sum %h flags %b,",
                                  " got row %0d sum %h flags %b"},
                                 want.row, want.sum, want.flags,
                                 m_row_index, m_row_sum, m_row_flags);
                end
            end
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d rows outstanding",
                         QUIET_LIMIT, pending_rows.size());
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : main_sequence
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = CC_RESET;
        s_valid       = 1'b0;
        s_command     = CMD_LOAD;
        s_column      = '0;
        s_entry_value = '0;
        s_row_end     = 1'b0;
        m_ready       = 1'b0;
        acc_mirror    = '0;
        row_mirror    = '0;
        flag_mirror   = '0;
        width_mirror  = CC_RESET;
        mismatches    = 0;
        rows_checked  = 0;
        sat_rows      = 0;
        bad_col_rows  = 0;
        items_sent    = 0;
        widths_tried  = 1;
        quiet_cycles  = 0;
        stall_left    = 0;
        idle_on       = 1'b1;
        stall_on      = 1'b1;
        foreach (x_loaded[k]) x_loaded[k] = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_extremes();
        test_bad_columns();
        test_random_widths();
        wait_drained();

        $display("Sent %0d items across %0d column_count settings; checked %0d rows.",
                 items_sent, widths_tried, rows_checked);
        $display("Rows that saturated: %0d, rows with bad columns: %0d, mismatches: %0d.",
                 sat_rows, bad_col_rows, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: csr_matrix_vector_multiply.f
rtl/spmv_pkg.sv
rtl/spmv_vector_store.sv
rtl/spmv_multiply.sv
rtl/spmv_accumulate.sv
rtl/csr_matrix_vector_multiply.sv
verif/tb.sv
